// ----- hdl/csrmv_pkg.sv -----
// shared types, widths and codes of the sparse matrix-vector block
package csrmv_pkg;

	localparam int MAX_DIM_DEF   = 4096;
	localparam int FRAC_BITS_DEF = 16;

	localparam int ACT_W      = 2;
	localparam int IDX_W      = 12;
	localparam int VAL_W      = 32;
	localparam int ACC_W      = 64;
	localparam int CFG_W      = 13;
	localparam int CFG_ADDR_W = 2;
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 48;
	localparam int M_USER_W   = 2;

	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_NZ    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EMPTY = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 2'd1;

	typedef struct packed {
		logic             rd;
		logic             wr;
		logic [IDX_W-1:0] idx;
	} vs_req_t;

endpackage

// ----- hdl/csr_sparse_matvec_top.sv -----
// sparse csr matrix times dense vector, streaming top level
//
// s_* carries input words: tuser is the action (load vector element, matrix
// nonzero, end of empty row), tdata holds the index and the q16.16 value,
// tlast marks the last nonzero of a row. m_* carries one word per finished
// row: the rounded, saturated q16.16 sum and row number in tdata, the bad
// column and saturated flags in tuser, tlast when it is the last row.
// cfg_* writes num_rows (index 0) and num_cols (index 1); always ready.
// one input word per clock while s_tready is high; the vector store is
// read or written at the accept edge and one 32x32 multiply plus one 64-bit
// accumulate per clock keep the rate. the word ending a row passes s1 to s4
// and the output register before its sum shows on m_tvalid. the output
// register lets input flow on while a sum waits; s_tready drops only when a
// second sum reaches the output stage behind one the receiver has not taken.
// reset clears the pipeline, accumulator, row counter and error flag and
// sets both dimensions to 1; vector contents are undefined until loaded.
module csr_sparse_matvec_top #(
	parameter int MAX_DIM   = csrmv_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = csrmv_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [csrmv_pkg::S_DATA_W-1:0]    s_tdata,  // index, value, zero pad
	input  logic                              s_tlast,
	input  logic [csrmv_pkg::ACT_W-1:0]       s_tuser,  // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [csrmv_pkg::M_DATA_W-1:0]    m_tdata,  // row_sum, row_number, zero pad
	output logic                              m_tlast,
	output logic [csrmv_pkg::M_USER_W-1:0]    m_tuser,  // bad_column, saturated
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csrmv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [csrmv_pkg::CFG_W-1:0]       cfg_data
);
	import csrmv_pkg::*;

	localparam int  DEPTH   = (MAX_DIM < (1 << IDX_W)) ? MAX_DIM : (1 << IDX_W);
	localparam int  RB      = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
	localparam bit  HAS_RND = FRAC_BITS > 0;

	typedef struct packed {
		logic mac;
		logic bad;
		logic last;
	} ctl_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = CFG_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W:0]   s;
		logic signed [ACC_W-1:0] r;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = s[ACC_W-1:0];
		end
		return r;
	endfunction

	logic [CFG_W-1:0] num_rows_q, num_cols_q;

	logic              en, out_free, in_acc;
	logic [ACT_W-1:0]  in_act;
	logic [IDX_W-1:0]  in_idx;
	logic [VAL_W-1:0]  in_val;
	logic              in_rng;
	vs_req_t           vs_req;
	logic [VAL_W-1:0]  vs_rdata;

	logic              v_s1, v_s2, v_s3, v_s4;
	ctl_t              ctl_s1, ctl_s2;
	logic [VAL_W-1:0]  val_s1;
	logic signed [ACC_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q, acc_sum, fin_s3;
	logic              col_err_q, col_now;
	logic [CFG_W-1:0]  row_q;
	logic [IDX_W-1:0]  row_s3, row_s4;
	logic              bad_s3, last_s3, bad_s4, last_s4;
	logic signed [ACC_W-1:0] rnd_s4;

	logic              out_v_q, sat_q, bad_q, last_q;
	logic [VAL_W-1:0]  sum_q;
	logic [IDX_W-1:0]  rown_q;
	logic              clip;
	logic [VAL_W-1:0]  clip_val;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CFG_W'(1);
			num_cols_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_NUM_ROWS: num_rows_q <= clamp_dim(cfg_data);
				REG_NUM_COLS: num_cols_q <= clamp_dim(cfg_data);
				default: ;
			endcase
		end
	end

	// input decode and vector store access
	assign out_free = !out_v_q || m_tready;
	assign en       = out_free || !v_s4;
	assign s_tready = en;
	assign in_acc   = s_tvalid && en;
	assign in_act   = s_tuser;
	assign in_idx   = s_tdata[IDX_W-1:0];
	assign in_val   = s_tdata[IDX_W +: VAL_W];
	assign in_rng   = {1'b0, in_idx} < num_cols_q;

	assign vs_req.rd  = in_acc && (in_act == ACT_NZ);
	assign vs_req.wr  = in_acc && (in_act == ACT_LOAD);
	assign vs_req.idx = in_idx;

	csrmv_vstore #(
		.DEPTH (DEPTH)
	) u_vstore (
		.clk   (clk),
		.req   (vs_req),
		.wdata (in_val),
		.rdata (vs_rdata)
	);

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			v_s1       <= in_acc && ((in_act == ACT_NZ) || (in_act == ACT_EMPTY));
			ctl_s1.mac <= (in_act == ACT_NZ) && in_rng;
			ctl_s1.bad <= (in_act == ACT_NZ) && !in_rng;
			ctl_s1.last <= (in_act == ACT_EMPTY) || ((in_act == ACT_NZ) && s_tlast);
			v_s2       <= v_s1;
			ctl_s2     <= ctl_s1;
			v_s3       <= v_s2 && ctl_s2.last;
			v_s4       <= v_s3;
		end
	end

	// multiply
	always_ff @(posedge clk) begin
		if (en) begin
			val_s1  <= in_val;
			prod_s2 <= $signed(vs_rdata) * $signed(val_s1);
		end
	end

	// accumulate and close rows
	assign acc_sum = ctl_s2.mac ? sat_add(acc_q, prod_s2) : acc_q;
	assign col_now = col_err_q || ctl_s2.bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			col_err_q <= 1'b0;
			row_q     <= '0;
		end else if (en && v_s2) begin
			if (ctl_s2.last) begin
				acc_q     <= '0;
				col_err_q <= 1'b0;
				row_q     <= (row_q >= num_rows_q - CFG_W'(1)) ? '0 : row_q + CFG_W'(1);
			end else begin
				acc_q     <= acc_sum;
				col_err_q <= col_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2 && ctl_s2.last) begin
			fin_s3  <= acc_sum;
			bad_s3  <= col_now;
			row_s3  <= row_q[IDX_W-1:0];
			last_s3 <= row_q == num_rows_q - CFG_W'(1);
		end
		if (en) begin
			rnd_s4  <= (fin_s3 >>> FRAC_BITS)
				+ $signed(ACC_W'(HAS_RND ? fin_s3[RB] : 1'b0));
			bad_s4  <= bad_s3;
			row_s4  <= row_s3;
			last_s4 <= last_s3;
		end
	end

	// clip and output register
	assign clip     = !((&rnd_s4[ACC_W-1:VAL_W-1]) || !(|rnd_s4[ACC_W-1:VAL_W-1]));
	assign clip_val = rnd_s4[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s4) begin
			sum_q  <= clip ? clip_val : rnd_s4[VAL_W-1:0];
			sat_q  <= clip;
			bad_q  <= bad_s4;
			last_q <= last_s4;
			rown_q <= row_s4;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(M_DATA_W - IDX_W - VAL_W){1'b0}}, rown_q, sum_q};
	assign m_tuser  = {sat_q, bad_q};
	assign m_tlast  = last_q;

endmodule

// ----- hdl/csrmv_vstore.sv -----
// vector element store, one write or read per cycle, registered read data
module csrmv_vstore #(
	parameter int DEPTH = csrmv_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  csrmv_pkg::vs_req_t         req,
	input  logic [csrmv_pkg::VAL_W-1:0] wdata,
	output logic [csrmv_pkg::VAL_W-1:0] rdata
);
	import csrmv_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [VAL_W-1:0] mem [DEPTH];
	logic             in_rng;
	logic [AW-1:0]    addr;

	assign in_rng = 32'(req.idx) < DEPTH;
	assign addr   = req.idx[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr && in_rng) begin
			mem[addr] <= wdata;
		end
		if (req.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- hdl/csrmv_checker.sv -----
// port-level checks of the sparse matrix-vector top level
module csrmv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [csrmv_pkg::M_DATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic [csrmv_pkg::M_USER_W-1:0] m_tuser
);
	import csrmv_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	// input is held off only behind a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with no waiting result");

	// saturated sums sit at a bound
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |->
			(m_tdata[VAL_W-1:0] == 32'h7fff_ffff) || (m_tdata[VAL_W-1:0] == 32'h8000_0000))
		else $error("saturated flag without bound value");

	// unused pad bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:IDX_W+VAL_W] == '0)
		else $error("nonzero pad bits in result word");

endmodule

bind csr_sparse_matvec_top csrmv_checker u_csrmv_checker (.*);
